[rtl/esvm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the elliptic slab volume mask.
// Used by esvm_geom, esvm_radius, esvm_apply and the top level; depends on nothing.
package esvm_pkg;

    localparam int MAX_SIZE = 256;

    localparam logic [23:0] ONE_Q16     = 24'd65536;
    localparam logic [23:0] R_SIGMA_Q16 = 24'd91750;
    localparam logic [23:0] R_SAT_Q16   = 24'hFFFFFF;
    localparam logic [16:0] W_ONE       = 17'd65536;

    typedef enum logic [2:0] {
        CFG_VOLUME_SIZE   = 3'd0,
        CFG_HEIGHT_LIMIT  = 3'd1,
        CFG_COS_ANGLE     = 3'd2,
        CFG_SIN_ANGLE     = 3'd3,
        CFG_INV_A_SQUARED = 3'd4,
        CFG_INV_B_SQUARED = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic        [8:0]  volume_size;
        logic        [15:0] height_limit;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic        [23:0] inv_a_squared;
        logic        [23:0] inv_b_squared;
    } cfg_t;

    // Geometry pipeline result: gate, squared rotated offsets and the voxel sample.
    typedef struct packed {
        logic               gate;
        logic        [21:0] xsq;
        logic        [21:0] ysq;
        logic signed [31:0] voxel;
    } geom_t;

    // Weight pipeline result.
    typedef struct packed {
        logic        [16:0] weight;
        logic signed [31:0] voxel;
    } weight_t;

endpackage

[rtl/esvm_geom.sv]
`timescale 1ns / 1ps
// Geometry stages: center offsets, height gate, rotation, magnitudes, squares.
// Depends on esvm_pkg.
module esvm_geom (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  esvm_pkg::cfg_t        cfg,
    input  logic                  in_fire,
    input  logic [7:0]            plane_index,
    input  logic [7:0]            row_index,
    input  logic [7:0]            column_index,
    input  logic signed [31:0]    voxel_value,
    output logic                  geom_valid,
    output esvm_pkg::geom_t       geom
);
    import esvm_pkg::*;

    // Stage 1: offsets and gate
    logic [8:0]         size_c;
    logic [7:0]         center;
    logic signed [9:0]  dz;
    logic [7:0]         dz_abs;
    logic               v1_reg;
    logic               gate1_reg;
    logic signed [9:0]  x1_reg, y1_reg;
    logic signed [31:0] vox1_reg;

    // Stage 2: products
    logic               v2_reg;
    logic               gate2_reg;
    logic signed [25:0] pcx2_reg, psy2_reg, psx2_reg, pcy2_reg;
    logic signed [31:0] vox2_reg;

    // Stage 3: rotated magnitudes
    logic signed [26:0] xs, ys;
    logic [26:0]        xs_mag, ys_mag;
    logic               v3_reg;
    logic               gate3_reg;
    logic [10:0]        xa3_reg, ya3_reg;
    logic signed [31:0] vox3_reg;

    // Stage 4: squares
    logic               v4_reg;
    logic               gate4_reg;
    logic [21:0]        xq4_reg, yq4_reg;
    logic signed [31:0] vox4_reg;

    always_comb
    begin
        size_c = (32'(cfg.volume_size) > MAX_SIZE) ? 9'(MAX_SIZE) : cfg.volume_size;
        center = size_c[8:1];
        dz     = signed'({2'b00, plane_index}) - signed'({2'b00, center});
        dz_abs = dz[9] ? 8'(-dz) : dz[7:0];
    end

    always_comb
    begin
        xs     = 27'(pcx2_reg) - 27'(psy2_reg);
        ys     = 27'(psx2_reg) + 27'(pcy2_reg);
        xs_mag = xs[26] ? 27'(-xs) : 27'(xs);
        ys_mag = ys[26] ? 27'(-ys) : 27'(ys);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gate1_reg <= ({dz_abs, 8'h00} <= cfg.height_limit);
            x1_reg    <= signed'({2'b00, column_index}) - signed'({2'b00, center});
            y1_reg    <= signed'({2'b00, row_index}) - signed'({2'b00, center});
            vox1_reg  <= voxel_value;

            gate2_reg <= gate1_reg;
            pcx2_reg  <= 26'(cfg.cos_angle * x1_reg);
            psy2_reg  <= 26'(cfg.sin_angle * y1_reg);
            psx2_reg  <= 26'(cfg.sin_angle * x1_reg);
            pcy2_reg  <= 26'(cfg.cos_angle * y1_reg);
            vox2_reg  <= vox1_reg;

            // truncation toward zero: shift the magnitude
            gate3_reg <= gate2_reg;
            xa3_reg   <= xs_mag[24:14];
            ya3_reg   <= ys_mag[24:14];
            vox3_reg  <= vox2_reg;

            gate4_reg <= gate3_reg;
            xq4_reg   <= 22'(xa3_reg) * 22'(xa3_reg);
            yq4_reg   <= 22'(ya3_reg) * 22'(ya3_reg);
            vox4_reg  <= vox3_reg;
        end
    end

    assign geom_valid = v4_reg;
    assign geom.gate  = gate4_reg;
    assign geom.xsq   = xq4_reg;
    assign geom.ysq   = yq4_reg;
    assign geom.voxel = vox4_reg;

endmodule

[rtl/esvm_radius.sv]
`timescale 1ns / 1ps
// Radius stages: scaled squares, saturated r, and the soft-edge weight.
// Depends on esvm_pkg.
module esvm_radius (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  esvm_pkg::cfg_t        cfg,
    input  logic                  geom_valid,
    input  esvm_pkg::geom_t       geom,
    output logic                  wt_valid,
    output esvm_pkg::weight_t     wt
);
    import esvm_pkg::*;

    logic               v5_reg;
    logic               gate5_reg;
    logic [45:0]        qa5_reg, qb5_reg;
    logic signed [31:0] vox5_reg;

    logic [46:0]        qsum;
    logic [38:0]        qsh;
    logic               v6_reg;
    logic               gate6_reg;
    logic [23:0]        r6_reg;
    logic signed [31:0] vox6_reg;

    logic [16:0]        band_diff;
    logic [18:0]        band5;
    logic [16:0]        weight_next;
    logic               v7_reg;
    logic [16:0]        w7_reg;
    logic signed [31:0] vox7_reg;

    always_comb
    begin
        qsum = 47'(qa5_reg) + 47'(qb5_reg);
        qsh  = qsum[46:8];
    end

    always_comb
    begin
        band_diff = 17'(R_SIGMA_Q16 - r6_reg);
        band5     = {band_diff, 2'b00} + 19'(band_diff);
        if (!gate6_reg)
            weight_next = '0;
        else if (r6_reg < ONE_Q16)
            weight_next = W_ONE;
        else if (r6_reg < R_SIGMA_Q16)
            weight_next = band5[17:1];
        else
            weight_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= geom_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gate5_reg <= geom.gate;
            qa5_reg   <= 46'(geom.xsq) * 46'(cfg.inv_a_squared);
            qb5_reg   <= 46'(geom.ysq) * 46'(cfg.inv_b_squared);
            vox5_reg  <= geom.voxel;

            // saturate r at the top of Q8.16
            gate6_reg <= gate5_reg;
            r6_reg    <= (|qsh[38:24]) ? R_SAT_Q16 : qsh[23:0];
            vox6_reg  <= vox5_reg;

            w7_reg    <= weight_next;
            vox7_reg  <= vox6_reg;
        end
    end

    assign wt_valid  = v7_reg;
    assign wt.weight = w7_reg;
    assign wt.voxel  = vox7_reg;

endmodule

[rtl/esvm_apply.sv]
`timescale 1ns / 1ps
// Apply stages: sample times weight, rounding toward zero, output register.
// Depends on esvm_pkg.
module esvm_apply (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  wt_valid,
    input  esvm_pkg::weight_t     wt,
    output logic                  out_valid,
    output logic signed [31:0]    masked_value,
    output logic [16:0]           mask_weight
);
    import esvm_pkg::*;

    logic               v8_reg;
    logic signed [49:0] prod8_reg;
    logic [16:0]        w8_reg;

    logic signed [49:0] prod_adj;
    logic signed [49:0] prod_sh;
    logic               v9_reg;
    logic signed [31:0] m9_reg;
    logic [16:0]        w9_reg;

    always_comb
    begin
        // bias negative products so the shift truncates toward zero
        prod_adj = prod8_reg[49] ? (prod8_reg + 50'sd65535) : prod8_reg;
        prod_sh  = prod_adj >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg <= wt_valid;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod8_reg <= 50'(wt.voxel) * signed'(50'(wt.weight));
            w8_reg    <= wt.weight;
            m9_reg    <= prod_sh[31:0];
            w9_reg    <= w8_reg;
        end
    end

    assign out_valid    = v9_reg;
    assign masked_value = m9_reg;
    assign mask_weight  = w9_reg;

endmodule

[rtl/elliptic_slab_volume_mask.sv]
`timescale 1ns / 1ps
// Top level of the elliptic slab volume mask: configuration registers and
// pipeline control. Depends on esvm_pkg, esvm_geom, esvm_radius, esvm_apply.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   input   | in_valid, in_stall, plane/row/column_index, voxel | in
//   output  | out_valid, out_stall, masked_value, mask_weight   | out
//   config  | cfg_we, cfg_index, cfg_data                       | in
//
// Nine register stages; one transaction per cycle while the output is not held.
// Stage depth is set by the 22x24 scaling multipliers and the 32x17 product.
// A stall on a valid output holds the whole pipeline in place; in_stall rises
// in the same cycle. Reset clears valid bits and loads register defaults.
module elliptic_slab_volume_mask (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         plane_index,
    input  logic [7:0]         row_index,
    input  logic [7:0]         column_index,
    input  logic signed [31:0] voxel_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] masked_value,
    output logic [16:0]        mask_weight,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import esvm_pkg::*;

    cfg_t    cfg_reg;
    logic    en;
    logic    in_fire;
    logic    geom_valid;
    geom_t   geom;
    logic    wt_valid;
    weight_t wt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume_size   <= 9'd128;
            cfg_reg.height_limit  <= 16'd16384;
            cfg_reg.cos_angle     <= 16'sd16384;
            cfg_reg.sin_angle     <= 16'sd0;
            cfg_reg.inv_a_squared <= 24'd16384;
            cfg_reg.inv_b_squared <= 24'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VOLUME_SIZE:   cfg_reg.volume_size   <= cfg_data[8:0];
                CFG_HEIGHT_LIMIT:  cfg_reg.height_limit  <= cfg_data[15:0];
                CFG_COS_ANGLE:     cfg_reg.cos_angle     <= signed'(cfg_data[15:0]);
                CFG_SIN_ANGLE:     cfg_reg.sin_angle     <= signed'(cfg_data[15:0]);
                CFG_INV_A_SQUARED: cfg_reg.inv_a_squared <= cfg_data;
                CFG_INV_B_SQUARED: cfg_reg.inv_b_squared <= cfg_data;
                default:           ;  // drop writes to unknown indexes
            endcase
        end
    end

    // advance every stage unless a finished transaction is held at the output
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;
    assign in_fire  = in_valid && en;

    esvm_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg          (cfg_reg),
        .in_fire      (in_fire),
        .plane_index  (plane_index),
        .row_index    (row_index),
        .column_index (column_index),
        .voxel_value  (voxel_value),
        .geom_valid   (geom_valid),
        .geom         (geom)
    );

    esvm_radius u_radius (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg_reg),
        .geom_valid (geom_valid),
        .geom       (geom),
        .wt_valid   (wt_valid),
        .wt         (wt)
    );

    esvm_apply u_apply (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .wt_valid     (wt_valid),
        .wt           (wt),
        .out_valid    (out_valid),
        .masked_value (masked_value),
        .mask_weight  (mask_weight)
    );

endmodule

[rtl/esvm_check.sv]
`timescale 1ns / 1ps
// Port-level checks of the elliptic slab volume mask, bound to the top level.
// Depends on elliptic_slab_volume_mask.
module esvm_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] masked_value,
    input logic [16:0]        mask_weight
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(masked_value) && $stable(mask_weight))
        else $error("output transaction changed while stalled");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mask_weight <= 17'd65536)
        else $error("mask weight above one");

    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mask_weight == 17'd0 |-> masked_value == 32'sd0)
        else $error("masked value nonzero under zero weight");

    // a jammed output must back-pressure the input in the same cycle
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output is held");

endmodule

bind elliptic_slab_volume_mask esvm_check u_esvm_check (.*);
